/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rnfcm_pkg.sv */
// ---------------------------------------------------------------------------
// rnfcm_pkg
// Shared constants and types of the range-normalized false-color map.
// ---------------------------------------------------------------------------
`default_nettype none

package rnfcm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COLOR_STEPS_DEF  = 1024;

    // func selector codes
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_MAP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SEG,
        ST_SCALE,
        ST_COLOR
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

/* rtl/range_normalized_false_color_map.sv */
// ---------------------------------------------------------------------------
// range_normalized_false_color_map
// Two-pass min/max normalized heatmap colorizer, blue-cyan-green-yellow-red.
// ---------------------------------------------------------------------------
// Usage:
//  - Input beats on the s_axis group: tuser is func (0 scan, 1 map), tdata
//    is the signed sample, tlast is first_in_frame (restarts min/max, scan only).
//  - Scan beats update the running range in the accept cycle and give no
//    output beat; the next beat can follow right after.
//  - Map beats give one RGB beat on m_axis. k = floor(STEPS*(s-min)/(max-min))
//    is found by a bit-serial divider, one quotient bit per cycle; the beat passes
//    the prep, divide, segment, scale and color states, where the RGB beat is
//    loaded, and the sequencer returns to idle to take the next beat. Below-,
//    above- and flat-range samples skip the divider, from prep to segment.
//  - The divider loop sets the pace; one map beat is in flight at a time.
//  - The output beat sits in a register; a new input beat is taken while it
//    waits. If m_axis stalls, the next map beat holds in its color stage.
//  - Reset (i_rst_n low, synchronous) clears min and max to zero, drops the
//    output beat and returns the sequencer to idle.
// ---------------------------------------------------------------------------
`default_nettype none

module range_normalized_false_color_map #(
    parameter int SAMPLE_WIDTH = rnfcm_pkg::SAMPLE_WIDTH_DEF,
    parameter int COLOR_STEPS  = rnfcm_pkg::COLOR_STEPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // s_axis
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  i_s_axis_tdata,  // sample
    input  wire logic                               i_s_axis_tlast,  // first_in_frame
    input  wire logic                               i_s_axis_tuser,  // func
    // m_axis
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [23:0]                             o_m_axis_tdata   // blue, green, red (msb first)
);
    import rnfcm_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int QW    = $clog2(COLOR_STEPS);
    localparam int NW    = SW + QW;
    localparam int SEG   = COLOR_STEPS / 4;
    localparam int KMAX  = COLOR_STEPS - 1;
    // reciprocal of the segment length, exact for t = r0*256/SEG
    localparam int RSH   = 2 * QW + 8;
    localparam int XW    = QW + 8;
    localparam int PW    = XW + RSH;
    localparam logic [RSH-1:0] RECIP =
        RSH'(((64'd1 << RSH) + 64'(SEG) - 64'd1) / 64'(SEG));

    t_state r_state, n_state;

    logic signed [SW-1:0] r_low, r_high;
    logic signed [SW:0]   r_diff, r_den;
    logic [QW-1:0]        r_k;
    logic [1:0]           r_q;
    logic [QW-1:0]        r_r0;
    logic [XW-1:0]        r_tq;
    logic                 r_out_valid;
    logic [7:0]           r_red, r_green, r_blue;

    logic                 w_in_acc;
    logic signed [SW-1:0] w_s;
    logic                 w_flat, w_below, w_above;
    logic                 w_div_start;
    logic [NW-1:0]        w_num;
    t_div_stat            w_div_stat;
    logic [QW-1:0]        w_quot;
    logic [1:0]           w_q;
    logic [QW-1:0]        w_r0;
    logic [7:0]           w_t;
    logic                 w_slot_free;
    logic                 w_load_out;

    assign w_s      = $signed(i_s_axis_tdata[SW-1:0]);
    assign w_in_acc = i_s_axis_tvalid & o_s_axis_tready;

    // range checks on the registered differences
    assign w_flat  = (r_den <= 0);
    assign w_below = (r_diff <= 0);
    assign w_above = (r_diff >= r_den);
    assign w_num   = NW'(r_diff[SW-1:0]) * NW'(COLOR_STEPS);

    assign w_slot_free = ~r_out_valid | i_m_axis_tready;

    rnfcm_div #(
        .NW (NW),
        .DW (SW),
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_den[SW-1:0]),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // segment split of k
    always_comb begin
        if (r_k >= QW'(3 * SEG)) begin
            w_q = 2'd3;
        end else if (r_k >= QW'(2 * SEG)) begin
            w_q = 2'd2;
        end else if (r_k >= QW'(SEG)) begin
            w_q = 2'd1;
        end else begin
            w_q = 2'd0;
        end
    end

    always_comb begin
        case (w_q)
            2'd0:    w_r0 = r_k;
            2'd1:    w_r0 = r_k - QW'(SEG);
            2'd2:    w_r0 = r_k - QW'(2 * SEG);
            default: w_r0 = r_k - QW'(3 * SEG);
        endcase
    end

    // leftover indices of the last segment saturate
    assign w_t = (r_tq > XW'(255)) ? 8'd255 : r_tq[7:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid && (i_s_axis_tuser == FUNC_MAP)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (w_flat || w_below || w_above) begin
                    n_state = ST_SEG;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_SEG;
                end
            end
            ST_SEG: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_COLOR;
            end
            ST_COLOR: begin
                if (w_slot_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // running range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (w_in_acc && (i_s_axis_tuser == FUNC_SCAN)) begin
            if (i_s_axis_tlast) begin
                r_low  <= w_s;
                r_high <= w_s;
            end else begin
                if (w_s > r_high) begin
                    r_high <= w_s;
                end
                if (w_s < r_low) begin
                    r_low <= w_s;
                end
            end
        end
    end

    // map datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_diff <= {w_s[SW-1], w_s} - {r_low[SW-1], r_low};
            r_den  <= {r_high[SW-1], r_high} - {r_low[SW-1], r_low};
        end
        if (r_state == ST_PREP) begin
            if (w_flat || w_below) begin
                r_k <= '0;
            end else if (w_above) begin
                r_k <= QW'(KMAX);
            end
        end
        if ((r_state == ST_DIV) && w_div_stat.done) begin
            r_k <= w_quot;
        end
        if (r_state == ST_SEG) begin
            r_q  <= w_q;
            r_r0 <= w_r0;
        end
        if (r_state == ST_SCALE) begin
            r_tq <= XW'((PW'({r_r0, 8'd0}) * PW'(RECIP)) >> RSH);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            case (r_q)
                2'd0: begin
                    r_red <= 8'd0;   r_green <= w_t;          r_blue <= 8'd255;
                end
                2'd1: begin
                    r_red <= 8'd0;   r_green <= 8'd255;       r_blue <= 8'd255 - w_t;
                end
                2'd2: begin
                    r_red <= w_t;    r_green <= 8'd255;       r_blue <= 8'd0;
                end
                default: begin
                    r_red <= 8'd255; r_green <= 8'd255 - w_t; r_blue <= 8'd0;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_blue, r_green, r_red};

    `include "assert_macros.svh"

    `ASSERT_CLK(a_range_order, $signed(r_low) <= $signed(r_high), "min above max")
    `ASSERT_CLK(a_out_from_color,
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_COLOR), "output beat without color stage")
    `ASSERT_CLK(a_div_done_in_div,
        w_div_stat.done |-> (r_state == ST_DIV), "divider finished outside divide state")
    `ASSERT_NEXT(a_div_to_seg,
        (r_state == ST_DIV) && w_div_stat.done, r_state == ST_SEG, "quotient not taken")

endmodule

`default_nettype wire

/* rtl/rnfcm_div.sv */
// ---------------------------------------------------------------------------
// rnfcm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// Requires the quotient to fit QW bits (num >> QW below den).
// ---------------------------------------------------------------------------
`default_nettype none

module rnfcm_div #(
    parameter int NW = 42,
    parameter int DW = 32,
    parameter int QW = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [NW-1:0]         i_num,
    input  wire logic [DW-1:0]         i_den,
    output rnfcm_pkg::t_div_stat       o_stat,
    output logic      [QW-1:0]         o_quot
);
    import rnfcm_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_nsh;
    logic [QW-1:0] r_quot;

    logic [DW+1:0] w_trial;
    logic          w_ge;

    // trial subtract of the divisor from the remainder with the next bit in
    assign w_trial = {1'b0, r_rem, r_nsh[QW-1]} - {2'b00, r_den};
    assign w_ge    = ~w_trial[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NW-1:QW];
            r_nsh <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_trial[DW-1:0] : {r_rem[DW-2:0], r_nsh[QW-1]};
            r_nsh  <= {r_nsh[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the range-normalized false-color map. Scan beats
// build a min/max range, map beats are colorized against it; every RGB beat
// is compared with a local predictor fed by the accepted input beats.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rnfcm_pkg::*;

    localparam int     STEPS = COLOR_STEPS_DEF;
    localparam longint SMAX  = 64'sd2147483647;
    localparam longint SMIN  = -SMAX - 1;

    typedef struct {
        logic               func;
        logic signed [31:0] temp;
        logic               first;
    } t_temp_beat;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;     // sample
    logic        s_tlast = 1'b0;   // first_in_frame
    logic        s_tuser = 1'b0;   // func
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // blue, green, red (msb first)

    range_normalized_false_color_map dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_temp_beat beat_q[$];   // beats waiting to be offered
    t_rgb       color_q[$];  // colors owed by the block
    t_temp_beat cur_beat;

    logic signed [31:0] span_lo = '0;
    logic signed [31:0] span_hi = '0;

    bit steady = 1'b0;       // no idling on either side while set
    int mismatches = 0;
    int colors_seen = 0;
    int scan_beats = 0;
    int map_beats = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // color of one map sample against the current range
    function automatic t_rgb ramp_color(logic signed [31:0] s);
        longint diff, den, k, q, t;
        t_rgb   c;
        k = 0;
        if (span_hi > span_lo) begin
            diff = longint'(s) - longint'(span_lo);
            if (diff > 0) begin
                den = longint'(span_hi) - longint'(span_lo);
                k = (diff * STEPS) / den;
                if (k > STEPS - 1)
                    k = STEPS - 1;
            end
        end
        q = k / (STEPS / 4);
        if (q > 3)
            q = 3;
        t = ((k - q * (STEPS / 4)) * 256) / (STEPS / 4);
        if (t > 255)
            t = 255;
        case (q)
            0: begin c.red = 8'd0;   c.green = t[7:0];         c.blue = 8'd255;         end
            1: begin c.red = 8'd0;   c.green = 8'd255;         c.blue = 8'd255 - t[7:0]; end
            2: begin c.red = t[7:0]; c.green = 8'd255;         c.blue = 8'd0;           end
            default: begin
                c.red = 8'd255; c.green = 8'd255 - t[7:0]; c.blue = 8'd0;
            end
        endcase
        return c;
    endfunction

    // range update or owed color for one accepted beat
    function automatic void absorb_beat(t_temp_beat b);
        if (b.func == FUNC_SCAN) begin
            scan_beats++;
            if (b.first) begin
                span_lo = b.temp;
                span_hi = b.temp;
            end else begin
                if (b.temp > span_hi)
                    span_hi = b.temp;
                if (b.temp < span_lo)
                    span_lo = b.temp;
            end
        end else begin
            map_beats++;
            color_q.push_back(ramp_color(b.temp));
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_beat(cur_beat);
            if (!s_tvalid || s_tready) begin
                if (beat_q.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
                    cur_beat = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_beat.temp;
                    s_tlast  <= cur_beat.first;
                    s_tuser  <= cur_beat.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off once results flow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && colors_seen >= 80) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 18);
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && m_tvalid && m_tready) begin
            colors_seen <= colors_seen + 1;
            if (color_q.size() == 0) begin
                $error("unexpected color beat %h", m_tdata);
                mismatches++;
            end else begin
                want = color_q.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, m_tdata[15:8]);
                    mismatches++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_beat(logic func, longint v, logic first);
        t_temp_beat b;
        b.func  = func;
        b.temp  = v[31:0];
        b.first = first;
        beat_q.push_back(b);
    endtask

    // one scan pass followed by one map pass; returns the beats queued
    task automatic queue_frame(output int n);
        longint base, spread, v;
        int     n_scan, n_map, pick;
        pick = $urandom_range(9);
        if (pick <= 3)
            spread = longint'($urandom_range(1, 300));
        else if (pick <= 6)
            spread = longint'($urandom_range(1, 1 << 20));
        else if (pick <= 8)
            spread = longint'($urandom);
        else
            spread = 0;
        base = longint'($signed($urandom));
        if (base + spread > SMAX)
            base = SMAX - spread;
        n_scan = $urandom_range(1, 12);
        n_map  = $urandom_range(1, 20);
        // occasionally a scan pass that keeps the old range going
        for (int i = 0; i < n_scan; i++) begin
            if (i == 1)
                v = base;
            else if (i == 2)
                v = base + spread;
            else
                v = base + longint'($urandom_range(0, int'(spread[31:0])));
            push_beat(FUNC_SCAN, v, (i == 0) && ($urandom_range(19) != 0));
        end
        for (int i = 0; i < n_map; i++) begin
            pick = $urandom_range(9);
            if (pick <= 6)
                v = base + longint'($urandom_range(0, int'(spread[31:0])));
            else if (pick == 7)
                v = ($urandom_range(1) != 0) ? base : base + spread;
            else if (pick == 8) begin
                if ($urandom_range(1) != 0) begin
                    v = base - longint'($urandom_range(1, 1000));
                    if (v < SMIN)
                        v = SMIN;
                end else begin
                    v = base + spread + longint'($urandom_range(1, 1000));
                    if (v > SMAX)
                        v = SMAX;
                end
            end else
                v = longint'($signed($urandom));
            push_beat(FUNC_MAP, v, $urandom_range(9) == 0);
        end
        n = n_scan + n_map;
    endtask

    // whole frames mixed with stray beats of random selector and frame mark
    task automatic queue_random_batch(int target);
        int done, n;
        done = 0;
        while (done < target) begin
            if ($urandom_range(9) == 0) begin
                push_beat(1'($urandom_range(1)), longint'($signed($urandom)),
                          1'($urandom_range(1)));
                done++;
            end else begin
                queue_frame(n);
                done += n;
            end
        end
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || s_tvalid || color_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // flat range straight after reset, frame mark on a map beat ignored
        push_beat(FUNC_MAP, 0, 1'b0);
        push_beat(FUNC_MAP, SMAX, 1'b1);
        // scan without a restart grows from the reset range
        push_beat(FUNC_SCAN, SMIN, 1'b0);
        push_beat(FUNC_SCAN, SMAX, 1'b0);
        // full-width range: ends, middle, sample at the maximum
        push_beat(FUNC_MAP, SMIN, 1'b0);
        push_beat(FUNC_MAP, SMAX, 1'b0);
        push_beat(FUNC_MAP, 0, 1'b0);
        push_beat(FUNC_MAP, -1, 1'b0);
        // restart to a flat range
        push_beat(FUNC_SCAN, 100, 1'b1);
        push_beat(FUNC_SCAN, 100, 1'b0);
        push_beat(FUNC_MAP, 100, 1'b0);
        push_beat(FUNC_MAP, 5000, 1'b0);
        // range of 1024: segment edges, top, above and below
        push_beat(FUNC_SCAN, 1124, 1'b0);
        push_beat(FUNC_MAP, 356, 1'b0);
        push_beat(FUNC_MAP, 355, 1'b0);
        push_beat(FUNC_MAP, 612, 1'b0);
        push_beat(FUNC_MAP, 868, 1'b0);
        push_beat(FUNC_MAP, 1123, 1'b0);
        push_beat(FUNC_MAP, 1124, 1'b0);
        push_beat(FUNC_MAP, 1200, 1'b0);
        push_beat(FUNC_MAP, 50, 1'b0);
        push_beat(FUNC_MAP, 99, 1'b0);
        drain();

        // first random batch sees the long receiver hold-off
        queue_random_batch(700);
        drain();
        steady = 1'b1;
        queue_random_batch(500);
        drain();
        steady = 1'b0;
        queue_random_batch(650);
        drain();
        repeat (40) @(negedge i_clk);

        $display("covered %0d scan beats and %0d map beats, %0d colors checked",
                 scan_beats, map_beats, colors_seen);
        $display("flat, full-width and narrow ranges, clamps, stalls and a 400-cycle hold-off");
        if (mismatches == 0 && color_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
